@@ rtl/core/vrcc_pkg.sv @@
// ----------------------------------------------------------------------------
// vrcc_pkg
// Shared types, constants and helpers for the vertex-removal component counter.
// ----------------------------------------------------------------------------
package vrcc_pkg;

    localparam int MAX_VERTICES_DEF = 512;
    localparam int NUM_W            = 10;
    localparam int VTX_W            = 9;
    localparam int WORD_W           = 64;
    localparam logic [NUM_W-1:0] NUM_VERTICES_RST = 10'd512;

    localparam logic OP_ADD_EDGE = 1'b0;
    localparam logic OP_REMOVE   = 1'b1;

    typedef enum logic [4:0] {
        S_SWEEP,
        S_IDLE,
        S_E_RD0,
        S_E_WR0,
        S_E_RD1,
        S_E_WR1,
        S_C_INIT,
        S_C_SCAN_RD,
        S_C_SCAN_CHK,
        S_C_POP,
        S_C_POPW,
        S_C_NB_RD,
        S_C_NB_CHK,
        S_C_PUSH,
        S_C_VCLR,
        S_R_ROW_RD,
        S_R_ROW_WR,
        S_R_COL_RD,
        S_R_COL_WR,
        S_DONE
    } t_state;

    // low k bits set, k from 0 to 64
    function automatic logic [WORD_W-1:0] f_low_mask(input logic [6:0] k);
        logic [WORD_W-1:0] m;
        for (int i = 0; i < WORD_W; i++) begin
            m[i] = (7'(i) < k);
        end
        return m;
    endfunction

    // position of the lowest set bit
    function automatic logic [5:0] f_first_one(input logic [WORD_W-1:0] x);
        logic [5:0] idx;
        idx = 6'd0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (x[i]) begin
                idx = 6'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ rtl/core/vrcc_ram.sv @@
// ----------------------------------------------------------------------------
// vrcc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module vrcc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

@@ rtl/core/vertex_removal_component_counter_core.sv @@
// ----------------------------------------------------------------------------
// vertex_removal_component_counter_core
// Graph held as a bit adjacency matrix in RAM; removals report the number of
// connected components found by a depth-first walk with a RAM stack.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                  payload
//  in       input      i_in_valid / o_in_ready    operation, vertex_a, vertex_b
//  out      output     o_out_valid / i_out_ready  removed_vertex .. bad_index
//  cfg      input      i_cfg_valid / o_cfg_ready  num_vertices
//
//  After reset a clearing pass writes every adjacency word; no item is taken
//  meanwhile. A count walks n vertices with W = ceil(n/64) words per row; a
//  removal is one or two counts plus clearing of the W row words and the n
//  column bits of the removed vertex.
//  A waiting result holds the next removal in its report state, and with it
//  the input, until the result is taken.
// ----------------------------------------------------------------------------
module vertex_removal_component_counter_core #(
    parameter int MAX_VERTICES = vrcc_pkg::MAX_VERTICES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_operation,
    input  logic [vrcc_pkg::VTX_W-1:0]  i_vertex_a,
    input  logic [vrcc_pkg::VTX_W-1:0]  i_vertex_b,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [vrcc_pkg::VTX_W-1:0]  o_removed_vertex,
    output logic [vrcc_pkg::NUM_W-1:0]  o_component_count,
    output logic                        o_alert,
    output logic                        o_game_over,
    output logic                        o_bad_index,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [vrcc_pkg::NUM_W-1:0]  i_cfg_data
);

    localparam int NUM_W     = vrcc_pkg::NUM_W;
    localparam int WORD_W    = vrcc_pkg::WORD_W;
    localparam int ROW_WORDS = (MAX_VERTICES + 63) / 64;
    localparam int VW        = $clog2(MAX_VERTICES);
    localparam int WW        = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
    localparam int NW        = $clog2(MAX_VERTICES + 1);
    localparam int CW0       = (NW > NUM_W) ? NW : NUM_W;
    localparam int CW        = (CW0 > WW + 7) ? CW0 : WW + 7;
    localparam int AW        = VW + WW;
    localparam int ADJ_DEPTH = 2 ** AW;
    localparam int VIS_DEPTH = 2 ** WW;

    // ---------------- registers
    vrcc_pkg::t_state r_state, n_state;
    logic [NUM_W-1:0]  r_num, n_num;
    logic              r_stale, n_stale;
    logic [NUM_W-1:0]  r_prev, n_prev;
    logic [NUM_W-1:0]  r_rn, n_rn;
    logic [CW-1:0]     r_a, n_a;
    logic [CW-1:0]     r_b, n_b;
    logic              r_phase, n_phase;
    logic [CW-1:0]     r_s, n_s;
    logic [WW:0]       r_w, n_w;
    logic [VW:0]       r_sp, n_sp;
    logic [NUM_W-1:0]  r_cnt, n_cnt;
    logic [VW-1:0]     r_v, n_v;
    logic [WORD_W-1:0] r_new, n_new;
    logic [AW-1:0]     r_sweep, n_sweep;
    logic              r_o_valid, n_o_valid;
    logic [vrcc_pkg::VTX_W-1:0] r_o_vertex, n_o_vertex;
    logic [NUM_W-1:0]  r_o_count, n_o_count;
    logic              r_o_alert, n_o_alert;
    logic              r_o_over, n_o_over;
    logic              r_o_bad, n_o_bad;

    // ---------------- memory ports
    logic              adj_we;
    logic [AW-1:0]     adj_waddr, adj_raddr;
    logic [WORD_W-1:0] adj_wdata, adj_rdata;
    logic              vis_we;
    logic [WW-1:0]     vis_waddr, vis_raddr;
    logic [WORD_W-1:0] vis_wdata, vis_rdata;
    logic              stk_we;
    logic [VW-1:0]     stk_waddr, stk_raddr;
    logic [VW-1:0]     stk_wdata, stk_rdata;

    vrcc_ram #(.WIDTH(WORD_W), .DEPTH(ADJ_DEPTH)) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (adj_wdata),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    vrcc_ram #(.WIDTH(WORD_W), .DEPTH(VIS_DEPTH)) u_vis_ram (
        .i_clk   (i_clk),
        .i_we    (vis_we),
        .i_waddr (vis_waddr),
        .i_wdata (vis_wdata),
        .i_raddr (vis_raddr),
        .o_rdata (vis_rdata)
    );

    vrcc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // ---------------- derived values
    logic [CW-1:0]     n_act;
    logic [CW-1:0]     w_base, w_rem;
    logic [WORD_W-1:0] w_mask;
    logic [WW-1:0]     a_word, b_word, s_word;
    logic [CW-1:0]     in_a, in_b;
    logic [CW-1:0]     nb_idx;
    logic [NUM_W:0]    prev_plus;
    logic [NUM_W-1:0]  rn_inc;
    logic              a_bad;

    assign n_act  = (CW'(r_num) > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(r_num);
    assign w_base = CW'({r_w, 6'b0});
    assign w_rem  = n_act - w_base;
    assign w_mask = (w_base >= n_act) ? '0 :
                    (w_rem >= CW'(WORD_W)) ? '1 : vrcc_pkg::f_low_mask(w_rem[6:0]);
    assign a_word = WW'(r_a >> 6);
    assign b_word = WW'(r_b >> 6);
    assign s_word = WW'(r_s >> 6);
    assign in_a   = CW'(i_vertex_a);
    assign in_b   = CW'(i_vertex_b);
    assign nb_idx = w_base + CW'(vrcc_pkg::f_first_one(r_new));
    assign prev_plus = {1'b0, r_prev} + (NUM_W+1)'(1);
    assign rn_inc = r_rn + NUM_W'(1);
    assign a_bad  = (r_a >= n_act);

    assign o_in_ready  = (r_state == vrcc_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;

    // ---------------- next state
    always_comb begin
        n_state    = r_state;
        n_num      = r_num;
        n_stale    = r_stale;
        n_prev     = r_prev;
        n_rn       = r_rn;
        n_a        = r_a;
        n_b        = r_b;
        n_phase    = r_phase;
        n_s        = r_s;
        n_w        = r_w;
        n_sp       = r_sp;
        n_cnt      = r_cnt;
        n_v        = r_v;
        n_new      = r_new;
        n_sweep    = r_sweep;
        n_o_valid  = r_o_valid && !i_out_ready;
        n_o_vertex = r_o_vertex;
        n_o_count  = r_o_count;
        n_o_alert  = r_o_alert;
        n_o_over   = r_o_over;
        n_o_bad    = r_o_bad;
        adj_we     = 1'b0;
        adj_waddr  = {r_a[VW-1:0], b_word};
        adj_wdata  = '0;
        adj_raddr  = {r_a[VW-1:0], b_word};
        vis_we     = 1'b0;
        vis_waddr  = r_w[WW-1:0];
        vis_wdata  = '0;
        vis_raddr  = r_w[WW-1:0];
        stk_we     = 1'b0;
        stk_waddr  = r_sp[VW-1:0];
        stk_wdata  = r_s[VW-1:0];
        stk_raddr  = r_sp[VW-1:0] - VW'(1);

        case (r_state)
            vrcc_pkg::S_SWEEP: begin
                adj_we    = 1'b1;
                adj_waddr = r_sweep;
                vis_we    = 1'b1;
                vis_waddr = r_sweep[WW-1:0];
                n_sweep   = r_sweep + AW'(1);
                if (r_sweep == AW'(ADJ_DEPTH - 1)) begin
                    n_state = vrcc_pkg::S_IDLE;
                end
            end
            vrcc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_a = in_a;
                    n_b = in_b;
                    if (i_operation == vrcc_pkg::OP_ADD_EDGE) begin
                        if (in_a < n_act && in_b < n_act) begin
                            n_state = vrcc_pkg::S_E_RD0;
                        end
                    end else if (r_stale) begin
                        n_phase = 1'b0;
                        n_state = vrcc_pkg::S_C_INIT;
                    end else begin
                        n_phase = 1'b1;
                        n_w     = '0;
                        n_state = (in_a >= n_act) ? vrcc_pkg::S_C_INIT
                                                  : vrcc_pkg::S_R_ROW_RD;
                    end
                end
            end
            // ---- add edge: set both symmetric bits
            vrcc_pkg::S_E_RD0: begin
                adj_raddr = {r_a[VW-1:0], b_word};
                n_state   = vrcc_pkg::S_E_WR0;
            end
            vrcc_pkg::S_E_WR0: begin
                adj_we    = 1'b1;
                adj_waddr = {r_a[VW-1:0], b_word};
                adj_wdata = adj_rdata | (WORD_W'(1) << r_b[5:0]);
                n_state   = vrcc_pkg::S_E_RD1;
            end
            vrcc_pkg::S_E_RD1: begin
                adj_raddr = {r_b[VW-1:0], a_word};
                n_state   = vrcc_pkg::S_E_WR1;
            end
            vrcc_pkg::S_E_WR1: begin
                adj_we    = 1'b1;
                adj_waddr = {r_b[VW-1:0], a_word};
                adj_wdata = adj_rdata | (WORD_W'(1) << r_a[5:0]);
                n_stale   = 1'b1;
                n_state   = vrcc_pkg::S_IDLE;
            end
            // ---- component count
            vrcc_pkg::S_C_INIT: begin
                n_s     = '0;
                n_cnt   = '0;
                n_sp    = '0;
                n_state = vrcc_pkg::S_C_SCAN_RD;
            end
            vrcc_pkg::S_C_SCAN_RD: begin
                vis_raddr = s_word;
                if (r_s >= n_act) begin
                    n_w     = '0;
                    n_state = vrcc_pkg::S_C_VCLR;
                end else begin
                    n_state = vrcc_pkg::S_C_SCAN_CHK;
                end
            end
            vrcc_pkg::S_C_SCAN_CHK: begin
                n_s = r_s + CW'(1);
                if (vis_rdata[r_s[5:0]]) begin
                    n_state = vrcc_pkg::S_C_SCAN_RD;
                end else begin
                    // new component: mark and push the start vertex
                    n_cnt     = r_cnt + NUM_W'(1);
                    vis_we    = 1'b1;
                    vis_waddr = s_word;
                    vis_wdata = vis_rdata | (WORD_W'(1) << r_s[5:0]);
                    stk_we    = 1'b1;
                    stk_wdata = r_s[VW-1:0];
                    n_sp      = r_sp + (VW+1)'(1);
                    n_state   = vrcc_pkg::S_C_POP;
                end
            end
            vrcc_pkg::S_C_POP: begin
                if (r_sp == '0) begin
                    n_state = vrcc_pkg::S_C_SCAN_RD;
                end else begin
                    n_sp    = r_sp - (VW+1)'(1);
                    n_state = vrcc_pkg::S_C_POPW;
                end
            end
            vrcc_pkg::S_C_POPW: begin
                n_v     = stk_rdata;
                n_w     = '0;
                n_state = vrcc_pkg::S_C_NB_RD;
            end
            vrcc_pkg::S_C_NB_RD: begin
                adj_raddr = {r_v, r_w[WW-1:0]};
                if (w_base >= n_act) begin
                    n_state = vrcc_pkg::S_C_POP;
                end else begin
                    n_state = vrcc_pkg::S_C_NB_CHK;
                end
            end
            vrcc_pkg::S_C_NB_CHK: begin
                n_new     = adj_rdata & ~vis_rdata & w_mask;
                vis_we    = 1'b1;
                vis_wdata = vis_rdata | (adj_rdata & w_mask);
                n_state   = vrcc_pkg::S_C_PUSH;
            end
            vrcc_pkg::S_C_PUSH: begin
                if (r_new == '0) begin
                    n_w     = r_w + (WW+1)'(1);
                    n_state = vrcc_pkg::S_C_NB_RD;
                end else begin
                    stk_we    = 1'b1;
                    stk_wdata = nb_idx[VW-1:0];
                    n_sp      = r_sp + (VW+1)'(1);
                    n_new     = r_new & (r_new - WORD_W'(1));
                end
            end
            vrcc_pkg::S_C_VCLR: begin
                vis_we = 1'b1;
                n_w    = r_w + (WW+1)'(1);
                if (r_w[WW-1:0] == '1) begin
                    n_w = '0;
                    if (!r_phase) begin
                        n_prev  = r_cnt;
                        n_phase = 1'b1;
                        n_state = a_bad ? vrcc_pkg::S_C_INIT : vrcc_pkg::S_R_ROW_RD;
                    end else begin
                        n_state = vrcc_pkg::S_DONE;
                    end
                end
            end
            // ---- removal: clear the row, then the column
            vrcc_pkg::S_R_ROW_RD: begin
                adj_raddr = {r_a[VW-1:0], r_w[WW-1:0]};
                if (w_base >= n_act) begin
                    n_s     = '0;
                    n_state = vrcc_pkg::S_R_COL_RD;
                end else begin
                    n_state = vrcc_pkg::S_R_ROW_WR;
                end
            end
            vrcc_pkg::S_R_ROW_WR: begin
                adj_we    = 1'b1;
                adj_waddr = {r_a[VW-1:0], r_w[WW-1:0]};
                adj_wdata = adj_rdata & ~w_mask;
                n_w       = r_w + (WW+1)'(1);
                n_state   = vrcc_pkg::S_R_ROW_RD;
            end
            vrcc_pkg::S_R_COL_RD: begin
                adj_raddr = {r_s[VW-1:0], a_word};
                if (r_s >= n_act) begin
                    n_state = vrcc_pkg::S_C_INIT;
                end else begin
                    n_state = vrcc_pkg::S_R_COL_WR;
                end
            end
            vrcc_pkg::S_R_COL_WR: begin
                adj_we    = 1'b1;
                adj_waddr = {r_s[VW-1:0], a_word};
                adj_wdata = adj_rdata & ~(WORD_W'(1) << r_a[5:0]);
                n_s       = r_s + CW'(1);
                n_state   = vrcc_pkg::S_R_COL_RD;
            end
            // ---- report; hold while the output register is still full
            vrcc_pkg::S_DONE: begin
                if (!r_o_valid || i_out_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_vertex = r_a[vrcc_pkg::VTX_W-1:0];
                    n_o_count  = r_cnt;
                    n_o_alert  = ({1'b0, r_cnt} > prev_plus);
                    n_o_over   = (n_act != '0) && (CW'(rn_inc) == n_act);
                    n_o_bad    = a_bad;
                    n_prev     = r_cnt;
                    n_rn       = rn_inc;
                    n_stale    = 1'b0;
                    n_state    = vrcc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = vrcc_pkg::S_IDLE;
            end
        endcase

        if (i_cfg_valid) begin
            n_num   = i_cfg_data;
            n_stale = 1'b1;
        end
    end

    // ---------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= vrcc_pkg::S_SWEEP;
            r_num     <= vrcc_pkg::NUM_VERTICES_RST;
            r_stale   <= 1'b1;
            r_prev    <= '0;
            r_rn      <= '0;
            r_phase   <= 1'b0;
            r_s       <= '0;
            r_w       <= '0;
            r_sp      <= '0;
            r_cnt     <= '0;
            r_sweep   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_num     <= n_num;
            r_stale   <= n_stale;
            r_prev    <= n_prev;
            r_rn      <= n_rn;
            r_phase   <= n_phase;
            r_s       <= n_s;
            r_w       <= n_w;
            r_sp      <= n_sp;
            r_cnt     <= n_cnt;
            r_sweep   <= n_sweep;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a        <= n_a;
        r_b        <= n_b;
        r_v        <= n_v;
        r_new      <= n_new;
        r_o_vertex <= n_o_vertex;
        r_o_count  <= n_o_count;
        r_o_alert  <= n_o_alert;
        r_o_over   <= n_o_over;
        r_o_bad    <= n_o_bad;
    end

    assign o_out_valid       = r_o_valid;
    assign o_removed_vertex  = r_o_vertex;
    assign o_component_count = r_o_count;
    assign o_alert           = r_o_alert;
    assign o_game_over       = r_o_over;
    assign o_bad_index       = r_o_bad;

    // ---------------- assertions
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= (VW+1)'(MAX_VERTICES))
        else $error("walk stack pointer beyond vertex count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vrcc_pkg::S_DONE) |-> (CW'(r_cnt) <= n_act))
        else $error("component count exceeds active vertices");

    a_bad_no_alert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_bad) |-> !r_o_alert)
        else $error("alert raised on out-of-range removal");

    a_sweep_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vrcc_pkg::S_SWEEP) |-> !o_in_ready)
        else $error("input taken during clearing pass");

endmodule

@@ tb/tb_vertex_removal_component_counter_core.sv @@
// ----------------------------------------------------------------------------
// tb_vertex_removal_component_counter_core
// Drives edge and removal transactions through the counter at several vertex
// counts and checks every removal report against a software graph model.
// ----------------------------------------------------------------------------
module tb_vertex_removal_component_counter_core;

    localparam int  GRAPH_MAX   = 512;
    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  SETTLE      = 100;

    typedef struct packed {
        logic [vrcc_pkg::VTX_W-1:0] vtx;
        logic [vrcc_pkg::NUM_W-1:0] cnt;
        logic                       alert;
        logic                       over;
        logic                       bad;
    } t_removal_report;

    // Graph model: holds the adjacency matrix and the removal reports owed.
    class removal_scoreboard;
        bit [GRAPH_MAX-1:0]         adj [GRAPH_MAX];
        int unsigned                nv;
        bit                         stale;
        int unsigned                prev_cnt;
        bit [vrcc_pkg::NUM_W-1:0]   removal_num;
        t_removal_report            owed_q [$];
        int unsigned                reports_checked;
        int unsigned                alerts_seen;
        int unsigned                overs_seen;
        int unsigned                bads_seen;

        function new();
            foreach (adj[i]) adj[i] = '0;
            nv          = GRAPH_MAX;
            stale       = 1'b1;
            prev_cnt    = 0;
            removal_num = '0;
        endfunction

        function int unsigned active_count();
            return (nv > GRAPH_MAX) ? GRAPH_MAX : nv;
        endfunction

        function void configure(logic [vrcc_pkg::NUM_W-1:0] value);
            nv    = value;
            stale = 1'b1;
        endfunction

        function int unsigned count_components(int unsigned n);
            bit [GRAPH_MAX-1:0] seen;
            int unsigned        walk [$];
            int unsigned        cnt;
            int unsigned        v;
            seen = '0;
            cnt  = 0;
            for (int unsigned s = 0; s < n; s++) begin
                if (!seen[s]) begin
                    cnt++;
                    seen[s] = 1'b1;
                    walk.push_back(s);
                    while (walk.size() > 0) begin
                        v = walk.pop_back();
                        for (int unsigned j = 0; j < n; j++) begin
                            if (!seen[j] && adj[v][j]) begin
                                seen[j] = 1'b1;
                                walk.push_back(j);
                            end
                        end
                    end
                end
            end
            return cnt;
        endfunction

        function void note_input(logic op, logic [vrcc_pkg::VTX_W-1:0] a,
                                 logic [vrcc_pkg::VTX_W-1:0] b);
            int unsigned     n;
            int unsigned     now_cnt;
            t_removal_report rep;
            n = active_count();
            if (op == vrcc_pkg::OP_ADD_EDGE) begin
                if (a < n && b < n) begin
                    adj[a][b] = 1'b1;
                    adj[b][a] = 1'b1;
                    stale     = 1'b1;
                end
                return;
            end
            if (stale) prev_cnt = count_components(n);
            rep.bad = (a >= n);
            if (!rep.bad) begin
                for (int unsigned j = 0; j < n; j++) begin
                    adj[a][j] = 1'b0;
                    adj[j][a] = 1'b0;
                end
            end
            now_cnt     = count_components(n);
            stale       = 1'b0;
            rep.alert   = (now_cnt > prev_cnt + 1);
            prev_cnt    = now_cnt;
            removal_num = removal_num + 1'b1;
            rep.over    = (n != 0) && (removal_num == n);
            rep.vtx     = a;
            rep.cnt     = vrcc_pkg::NUM_W'(now_cnt);
            owed_q.push_back(rep);
        endfunction

        // Return an empty string on a match, else a description of the mismatch.
        function string check_result(t_removal_report got);
            t_removal_report want;
            string           msg;
            if (owed_q.size() == 0) return $sformatf("unexpected report %p", got);
            want = owed_q.pop_front();
            reports_checked++;
            alerts_seen += want.alert;
            overs_seen  += want.over;
            bads_seen   += want.bad;
            msg = "";
            if (got.vtx != want.vtx)
                msg = {msg, $sformatf(" removed_vertex %0d/%0d", got.vtx, want.vtx)};
            if (got.cnt != want.cnt)
                msg = {msg, $sformatf(" component_count %0d/%0d", got.cnt, want.cnt)};
            if (got.alert != want.alert)
                msg = {msg, $sformatf(" alert %0b/%0b", got.alert, want.alert)};
            if (got.over != want.over)
                msg = {msg, $sformatf(" game_over %0b/%0b", got.over, want.over)};
            if (got.bad != want.bad)
                msg = {msg, $sformatf(" bad_index %0b/%0b", got.bad, want.bad)};
            return msg;
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic                       i_operation = vrcc_pkg::OP_ADD_EDGE;
    logic [vrcc_pkg::VTX_W-1:0] i_vertex_a = '0;
    logic [vrcc_pkg::VTX_W-1:0] i_vertex_b = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [vrcc_pkg::VTX_W-1:0] o_removed_vertex;
    logic [vrcc_pkg::NUM_W-1:0] o_component_count;
    logic                       o_alert;
    logic                       o_game_over;
    logic                       o_bad_index;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [vrcc_pkg::NUM_W-1:0] i_cfg_data = '0;

    removal_scoreboard sb = new();
    int unsigned       error_count = 0;
    int unsigned       cycle_count = 0;
    int unsigned       items_sent  = 0;
    bit                no_idle     = 1'b0;
    bit                hold_req    = 1'b0;

    vertex_removal_component_counter_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_operation       (i_operation),
        .i_vertex_a        (i_vertex_a),
        .i_vertex_b        (i_vertex_b),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_removed_vertex  (o_removed_vertex),
        .o_component_count (o_component_count),
        .o_alert           (o_alert),
        .o_game_over       (o_game_over),
        .o_bad_index       (o_bad_index),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report_error(string msg);
        $display("ERROR @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    task automatic send_item(logic op, logic [vrcc_pkg::VTX_W-1:0] a,
                             logic [vrcc_pkg::VTX_W-1:0] b);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_vertex_a  <= a;
        i_vertex_b  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(op, a, b);
        items_sent++;
    endtask

    task automatic add_edge(int unsigned a, int unsigned b);
        send_item(vrcc_pkg::OP_ADD_EDGE, vrcc_pkg::VTX_W'(a), vrcc_pkg::VTX_W'(b));
    endtask

    task automatic remove_vertex(int unsigned a);
        send_item(vrcc_pkg::OP_REMOVE, vrcc_pkg::VTX_W'(a),
                  vrcc_pkg::VTX_W'($urandom_range(0, 511)));
    endtask

    // Write the vertex count once the block has drained.
    task automatic write_num_vertices(int unsigned value);
        i_in_valid <= 1'b0;
        while (sb.owed_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= vrcc_pkg::NUM_W'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.configure(vrcc_pkg::NUM_W'(value));
    endtask

    task automatic random_phase(int unsigned n_items, int unsigned n);
        int unsigned a;
        int unsigned b;
        int unsigned lim;
        lim = (n == 0) ? 1 : ((n > GRAPH_MAX) ? GRAPH_MAX : n);
        for (int unsigned k = 0; k < n_items; k++) begin
            // keep most endpoints in range, the rest over the full field
            a = ($urandom_range(0, 9) < 8) ? $urandom_range(0, lim - 1) : $urandom_range(0, 511);
            b = ($urandom_range(0, 9) < 8) ? $urandom_range(0, lim - 1) : $urandom_range(0, 511);
            if ($urandom_range(0, 99) < 60) add_edge(a, b);
            else remove_vertex(a);
        end
    endtask

    // Receiver: random ready gaps, plus one long hold-off on request.
    initial begin
        int unsigned gap;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            msg = sb.check_result({o_removed_vertex, o_component_count, o_alert,
                                   o_game_over, o_bad_index});
            if (msg != "") report_error(msg);
        end
    end

    initial begin
        int unsigned n;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full-size graph at the reset vertex count: extremes and self loop.
        add_edge(0, 511);
        add_edge(511, 511);
        add_edge(5, 6);
        remove_vertex(511);
        remove_vertex(0);

        // Above the maximum: treated as the maximum.
        write_num_vertices(1023);
        add_edge(1, 510);
        remove_vertex(510);

        // No vertices: edges ignored, every removal out of range.
        write_num_vertices(0);
        add_edge(0, 0);
        remove_vertex(0);

        // Small star, then remove the hub to split it and raise an alert.
        write_num_vertices(6);
        add_edge(0, 1);
        add_edge(0, 2);
        add_edge(0, 3);
        add_edge(0, 4);
        add_edge(0, 6);
        add_edge(2, 511);
        remove_vertex(0);
        remove_vertex(300);
        remove_vertex(5);

        // Vertex count matching the next removal number sets game over.
        n = sb.removal_num + 1;
        write_num_vertices(n);
        remove_vertex(n - 1);

        write_num_vertices(1);
        add_edge(0, 0);
        remove_vertex(0);

        // Random phases with small graphs, one with back-to-back items.
        write_num_vertices($urandom_range(8, 24));
        hold_req = 1'b1;
        no_idle  = 1'b1;
        random_phase(25, sb.nv);
        no_idle  = 1'b0;

        write_num_vertices(2);
        random_phase(15, 2);

        write_num_vertices($urandom_range(3, 40));
        random_phase(30, sb.nv);

        n = sb.removal_num + $urandom_range(2, 6);
        write_num_vertices(n);
        random_phase(30, n);

        i_in_valid <= 1'b0;
        while (sb.owed_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("Sent %0d transactions; checked %0d removal reports", items_sent,
                 sb.reports_checked);
        $display("Reports with alert %0d, game over %0d, bad index %0d",
                 sb.alerts_seen, sb.overs_seen, sb.bads_seen);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
